/* sv/azr_pkg.sv */
// shared types, widths and helpers for the z-axis alignment rotation unit
// no dependencies; every module of the unit imports this package
package azr_pkg;

    // operand widths
    localparam int VEL_W  = 16;
    localparam int SQ_W   = 32;                 // x^2 + y^2 + z^2
    localparam int FRAC_W = 28;                 // Q.28 scaling shift
    localparam int HALF_W = 14;                 // Q.14 scaling shift
    localparam int RAD_W  = SQ_W + FRAC_W;      // sqrt radicand
    localparam int ROOT_W = 30;                 // |vel| in 2^-14 units
    localparam int NUM_W  = 64;                 // divider numerator
    localparam int DEN_W  = 46;                 // divider denominator
    localparam int QUO_W  = 31;                 // divider quotient bits
    localparam int CMP_W  = DEN_W + QUO_W;      // shifted divisor compare
    localparam int DIV_LAT = QUO_W + 1;         // entry stage plus one per bit
    localparam int PROD_W = 62;                 // 31 x 31 product

    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
    localparam logic signed [31:0] SAT_MAX = 32'sd32767;
    localparam logic signed [31:0] SAT_MIN = -32'sd32768;

    // input beat
    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_z;
    } t_vel;

    // result beat
    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
        logic               degenerate;
    } t_rot;

    // values carried alongside the root and the first divider bank
    typedef struct packed {
        logic signed [VEL_W-1:0] x;
        logic signed [VEL_W-1:0] y;
        logic signed [VEL_W-1:0] z;
        logic [30:0]             xx;
        logic [30:0]             yy;
        logic signed [31:0]      xy;
        logic [31:0]             p;
        logic                    ident;
        logic                    degen;
    } t_side;

    // values carried alongside the second divider bank
    typedef struct packed {
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] c;
        logic               ident;
        logic               degen;
    } t_side2;

    // clamp to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] res;
        if (v > SAT_MAX) begin
            res = 16'sh7fff;
        end else if (v < SAT_MIN) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

/* sv/align_z_axis_rotation_matrix_unit.sv */
// top level of the z-axis alignment rotation unit
// depends on azr_pkg, azr_sqrt and azr_div
//
// Usage: drive i_vel (signed Q8.8 velocity) and pulse i_start. A beat is
// taken at every rising edge where i_start is high and o_busy is low; o_busy
// stays low, so a new vector may be started in every cycle.
// The rotation that turns +z onto the velocity direction comes out on o_mat
// (nine signed Q2.14 entries plus the degenerate flag) with o_valid high for
// exactly one cycle. Results leave in start
// order, one per cycle at full rate.
// Latency is set by the pipeline: 30 root stages (one root bit each), two
// divider banks of 32 stages (rounding add plus one quotient bit per stage),
// and five single registers for input, squares, magnitudes, products and
// output. Throughput is one vector per cycle.
// A vector on the z axis gives the identity; degenerate is set when it is
// zero or points along -z.
// Synchronous reset clears all valid bits; beats in flight are dropped.
// The receiver cannot hold results off and needs no stall path.
module align_z_axis_rotation_matrix_unit import azr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    input  t_vel i_vel,
    output logic o_valid,
    output t_rot o_mat
);

    // input register
    logic r_in_vld;
    t_vel r_in;

    always_ff @(posedge i_clk) begin
        r_in <= i_vel;
    end

    // squares and cross term
    logic signed [31:0] w_xx_s, w_yy_s, w_zz_s, w_xy;
    logic [31:0]        w_p, w_sq;
    t_side              w_side1;
    logic               r1_vld;
    t_side              r1_side;
    logic [SQ_W-1:0]    r1_sq;

    always_comb begin
        w_xx_s = r_in.vel_x * r_in.vel_x;
        w_yy_s = r_in.vel_y * r_in.vel_y;
        w_zz_s = r_in.vel_z * r_in.vel_z;
        w_xy   = r_in.vel_x * r_in.vel_y;
        w_p    = unsigned'(w_xx_s) + unsigned'(w_yy_s);
        w_sq   = w_p + unsigned'(w_zz_s);
        w_side1.x     = r_in.vel_x;
        w_side1.y     = r_in.vel_y;
        w_side1.z     = r_in.vel_z;
        w_side1.xx    = w_xx_s[30:0];
        w_side1.yy    = w_yy_s[30:0];
        w_side1.xy    = w_xy;
        w_side1.p     = w_p;
        w_side1.ident = (w_p == '0);
        w_side1.degen = (w_p == '0) && (r_in.vel_z <= 16'sd0);
    end

    always_ff @(posedge i_clk) begin
        r1_side <= w_side1;
        r1_sq   <= w_sq;
    end

    // vector length
    logic              w_n_vld;
    logic [ROOT_W-1:0] w_n;
    t_side             w_n_side;

    azr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_vld),
        .i_sq    (r1_sq),
        .i_side  (r1_side),
        .o_valid (w_n_vld),
        .o_root  (w_n),
        .o_side  (w_n_side)
    );

    // numerator magnitudes for the first divider bank
    logic signed [VEL_W:0] w_ax, w_ay, w_az;
    logic signed [32:0]    w_m;
    logic                  r2_vld;
    logic [NUM_W-1:0]      r2_mx, r2_my, r2_mz, r2_mq;
    logic                  r2_nx, r2_ny, r2_nz;
    logic [DEN_W-1:0]      r2_den;
    t_side                 r2_side;

    always_comb begin
        w_ax = (w_n_side.x < 0) ? -(17'(w_n_side.x)) : 17'(w_n_side.x);
        w_ay = (w_n_side.y < 0) ? -(17'(w_n_side.y)) : 17'(w_n_side.y);
        w_az = (w_n_side.z < 0) ? -(17'(w_n_side.z)) : 17'(w_n_side.z);
        w_m  = signed'({3'b000, w_n}) - (33'(w_n_side.z) <<< HALF_W);
    end

    always_ff @(posedge i_clk) begin
        r2_mx   <= NUM_W'(unsigned'(w_ax[VEL_W-1:0])) << FRAC_W;
        r2_my   <= NUM_W'(unsigned'(w_ay[VEL_W-1:0])) << FRAC_W;
        r2_mz   <= NUM_W'(unsigned'(w_az[VEL_W-1:0])) << FRAC_W;
        r2_mq   <= NUM_W'(unsigned'(w_m[31:0])) << FRAC_W;
        r2_nx   <= w_n_side.x[VEL_W-1];
        r2_ny   <= w_n_side.y[VEL_W-1];
        r2_nz   <= w_n_side.z[VEL_W-1];
        r2_den  <= DEN_W'(w_n);
        r2_side <= w_n_side;
    end

    // first divider bank: unit vector and rounded (N - z) / N
    logic               w_b1_vld;
    logic signed [31:0] w_bx, w_by, w_c, w_q;
    t_side              r_d1 [DIV_LAT];

    azr_div u_div_bx (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r2_vld),
        .i_mag (r2_mx), .i_den (r2_den), .i_neg (r2_nx),
        .o_valid (w_b1_vld), .o_quo (w_bx)
    );

    azr_div u_div_by (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r2_vld),
        .i_mag (r2_my), .i_den (r2_den), .i_neg (r2_ny),
        .o_valid (), .o_quo (w_by)
    );

    azr_div u_div_c (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r2_vld),
        .i_mag (r2_mz), .i_den (r2_den), .i_neg (r2_nz),
        .o_valid (), .o_quo (w_c)
    );

    azr_div u_div_q (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r2_vld),
        .i_mag (r2_mq), .i_den (r2_den), .i_neg (1'b0),
        .o_valid (), .o_quo (w_q)
    );

    // sideband delay across the first bank
    always_ff @(posedge i_clk) begin
        r_d1[0] <= r2_side;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_d1[i] <= r_d1[i-1];
        end
    end

    // products for the k-terms
    t_side             w_s1;
    logic [30:0]       w_axy;
    logic              r3_vld;
    logic [PROD_W-1:0] r3_pyy, r3_pxx, r3_pxy;
    logic              r3_nxy;
    logic [DEN_W-1:0]  r3_den;
    t_side2            r3_side;

    always_comb begin
        w_s1  = r_d1[DIV_LAT-1];
        w_axy = (w_s1.xy < 0) ? 31'(-w_s1.xy) : w_s1.xy[30:0];
    end

    always_ff @(posedge i_clk) begin
        r3_pyy        <= w_s1.yy * w_q[30:0];
        r3_pxx        <= w_s1.xx * w_q[30:0];
        r3_pxy        <= w_axy * w_q[30:0];
        r3_nxy        <= w_s1.xy[31];
        r3_den        <= DEN_W'(w_s1.p) << HALF_W;
        r3_side.bx    <= w_bx;
        r3_side.by    <= w_by;
        r3_side.c     <= w_c;
        r3_side.ident <= w_s1.ident;
        r3_side.degen <= w_s1.degen;
    end

    // second divider bank: k-terms
    logic               w_b2_vld;
    logic signed [31:0] w_tyy, w_txx, w_txy;
    t_side2             r_d2 [DIV_LAT];

    azr_div u_div_tyy (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r3_vld),
        .i_mag (NUM_W'(r3_pyy)), .i_den (r3_den), .i_neg (1'b0),
        .o_valid (w_b2_vld), .o_quo (w_tyy)
    );

    azr_div u_div_txx (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r3_vld),
        .i_mag (NUM_W'(r3_pxx)), .i_den (r3_den), .i_neg (1'b0),
        .o_valid (), .o_quo (w_txx)
    );

    azr_div u_div_txy (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r3_vld),
        .i_mag (NUM_W'(r3_pxy)), .i_den (r3_den), .i_neg (r3_nxy),
        .o_valid (), .o_quo (w_txy)
    );

    // sideband delay across the second bank
    always_ff @(posedge i_clk) begin
        r_d2[0] <= r3_side;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_d2[i] <= r_d2[i-1];
        end
    end

    // matrix assembly with identity override
    t_side2 w_s2;
    t_rot   n_mat;
    t_rot   r_mat;
    logic   r_out_vld;

    always_comb begin
        w_s2 = r_d2[DIV_LAT-1];
        if (w_s2.ident) begin
            n_mat.r00 = ONE_Q14;
            n_mat.r01 = '0;
            n_mat.r02 = '0;
            n_mat.r10 = '0;
            n_mat.r11 = ONE_Q14;
            n_mat.r12 = '0;
            n_mat.r20 = '0;
            n_mat.r21 = '0;
            n_mat.r22 = ONE_Q14;
        end else begin
            n_mat.r00 = sat16(w_s2.c + w_tyy);
            n_mat.r01 = sat16(-w_txy);
            n_mat.r02 = sat16(w_s2.bx);
            n_mat.r10 = sat16(-w_txy);
            n_mat.r11 = sat16(w_s2.c + w_txx);
            n_mat.r12 = sat16(w_s2.by);
            n_mat.r20 = sat16(-w_s2.bx);
            n_mat.r21 = sat16(-w_s2.by);
            n_mat.r22 = sat16(w_s2.c);
        end
        n_mat.degenerate = w_s2.degen;
    end

    always_ff @(posedge i_clk) begin
        r_mat <= n_mat;
    end

    // valid bits of the single-register stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= i_start;
            r1_vld    <= r_in_vld;
            r2_vld    <= w_n_vld;
            r3_vld    <= w_b1_vld;
            r_out_vld <= w_b2_vld;
        end
    end

    assign o_busy  = 1'b0;
    assign o_valid = r_out_vld;
    assign o_mat   = r_mat;

endmodule

/* sv/azr_sqrt.sv */
// pipelined integer square root, one root bit per stage
// depends on azr_pkg; carries a t_side sideband with each beat
module azr_sqrt import azr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_sq,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic [RAD_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic              r_vld  [ROOT_W];
    t_side             r_sd   [ROOT_W];

    logic [RAD_W-1:0]  w_rem  [ROOT_W];
    logic [ROOT_W-1:0] w_root [ROOT_W];
    logic [RAD_W-1:0]  n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];

    // each stage tries the next root bit against the running remainder
    always_comb begin
        logic [RAD_W:0] trial;
        int             k;
        w_rem[0]  = {i_sq, FRAC_W'(0)};
        w_root[0] = '0;
        for (int s = 1; s < ROOT_W; s++) begin
            w_rem[s]  = r_rem[s-1];
            w_root[s] = r_root[s-1];
        end
        for (int s = 0; s < ROOT_W; s++) begin
            k     = ROOT_W - 1 - s;
            trial = ((RAD_W+1)'(w_root[s]) << (k + 1)) + ((RAD_W+1)'(1) << (2 * k));
            n_rem[s]  = w_rem[s];
            n_root[s] = w_root[s];
            if ((RAD_W+1)'(w_rem[s]) >= trial) begin
                n_rem[s]  = w_rem[s] - trial[RAD_W-1:0];
                n_root[s] = w_root[s] | (ROOT_W'(1) << k);
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < ROOT_W; s++) begin
            r_rem[s]  <= n_rem[s];
            r_root[s] <= n_root[s];
        end
        r_sd[0] <= i_side;
        for (int s = 1; s < ROOT_W; s++) begin
            r_sd[s] <= r_sd[s-1];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < ROOT_W; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < ROOT_W; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_sd[ROOT_W-1];

endmodule

/* sv/azr_div.sv */
// pipelined restoring divider, one quotient bit per stage, rounds half away
// from zero; depends on azr_pkg
module azr_div import azr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [NUM_W-1:0]    i_mag,
    input  logic [DEN_W-1:0]    i_den,
    input  logic                i_neg,
    output logic                o_valid,
    output logic signed [QUO_W:0] o_quo
);

    logic [NUM_W-1:0] r0_rem;
    logic [DEN_W-1:0] r0_den;
    logic             r0_neg;
    logic             r0_vld;

    logic [NUM_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic             r_neg [QUO_W];
    logic             r_vld [QUO_W];

    logic [NUM_W-1:0] w_rem [QUO_W];
    logic [QUO_W-1:0] w_quo [QUO_W];
    logic [DEN_W-1:0] w_den [QUO_W];
    logic [NUM_W-1:0] n_rem [QUO_W];
    logic [QUO_W-1:0] n_quo [QUO_W];

    logic signed [QUO_W:0] w_q;

    // entry stage adds half the divisor for rounding
    always_ff @(posedge i_clk) begin
        r0_rem <= i_mag + NUM_W'(i_den >> 1);
        r0_den <= i_den;
        r0_neg <= i_neg;
    end

    // one quotient bit per stage
    always_comb begin
        logic [CMP_W-1:0] shd;
        int               j;
        w_rem[0] = r0_rem;
        w_quo[0] = '0;
        w_den[0] = r0_den;
        for (int s = 1; s < QUO_W; s++) begin
            w_rem[s] = r_rem[s-1];
            w_quo[s] = r_quo[s-1];
            w_den[s] = r_den[s-1];
        end
        for (int s = 0; s < QUO_W; s++) begin
            j   = QUO_W - 1 - s;
            shd = CMP_W'(w_den[s]) << j;
            n_rem[s] = w_rem[s];
            n_quo[s] = w_quo[s];
            if (CMP_W'(w_rem[s]) >= shd) begin
                n_rem[s] = w_rem[s] - shd[NUM_W-1:0];
                n_quo[s] = w_quo[s] | (QUO_W'(1) << j);
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < QUO_W; s++) begin
            r_rem[s] <= n_rem[s];
            r_quo[s] <= n_quo[s];
        end
        r_den[0] <= r0_den;
        r_neg[0] <= r0_neg;
        for (int s = 1; s < QUO_W; s++) begin
            r_den[s] <= r_den[s-1];
            r_neg[s] <= r_neg[s-1];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            for (int s = 0; s < QUO_W; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r0_vld   <= i_valid;
            r_vld[0] <= r0_vld;
            for (int s = 1; s < QUO_W; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // apply sign
    assign w_q     = signed'({1'b0, r_quo[QUO_W-1]});
    assign o_quo   = r_neg[QUO_W-1] ? -w_q : w_q;
    assign o_valid = r_vld[QUO_W-1];

endmodule

/* test/azr_rot_checker.sv */
// checker for the z-axis alignment rotation unit: predicts each rotation and compares
// depends on azr_pkg for the beat types
module azr_rot_checker import azr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_vel i_vel,
    input  logic i_valid,
    input  t_rot i_mat,
    output int   o_fail_cnt,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_rot rot_expected_q[$];
    int   fail_cnt = 0;

    assign o_fail_cnt = fail_cnt;
    assign o_pending  = rot_expected_q.size();

    // floor square root, bit by bit
    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt >>= 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    // signed over unsigned, round half away from zero
    function automatic longint div_round(input longint num, input longint unsigned den);
        longint unsigned mag, qq;
        mag = (num < 0) ? longint'(0) - num : num;
        qq = (mag + den / 2) / den;
        return (num < 0) ? -longint'(qq) : longint'(qq);
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // rotation turning +z onto the velocity direction
    function automatic t_rot align_rotation(input t_vel v);
        t_rot r;
        longint x, y, z, p, n, bx, by, c, m, q, tyy, txx, txy;
        x = v.vel_x;
        y = v.vel_y;
        z = v.vel_z;
        p = x * x + y * y;
        r = '0;
        if (p == 0) begin
            r.r00 = ONE_Q14;
            r.r11 = ONE_Q14;
            r.r22 = ONE_Q14;
            r.degenerate = (z > 0) ? 1'b0 : 1'b1;
        end else begin
            n = root_floor((p + z * z) * 64'd268435456);
            bx = div_round(x * 268435456, n);
            by = div_round(y * 268435456, n);
            c = div_round(z * 268435456, n);
            m = n - z * 16384;
            q = div_round(m * 268435456, n);
            tyy = div_round(y * y * q, p * 16384);
            txx = div_round(x * x * q, p * 16384);
            txy = div_round(x * y * q, p * 16384);
            r.r00 = clamp16(c + tyy);
            r.r01 = clamp16(-txy);
            r.r02 = clamp16(bx);
            r.r10 = clamp16(-txy);
            r.r11 = clamp16(c + txx);
            r.r12 = clamp16(by);
            r.r20 = clamp16(-bx);
            r.r21 = clamp16(-by);
            r.r22 = clamp16(c);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_cnt++;
    endtask

    // watch both channels on the rising edge
    always @(posedge i_clk) begin
        t_rot want;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                rot_expected_q.push_back(align_rotation(i_vel));
            end
            if (i_valid) begin
                if (rot_expected_q.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    want = rot_expected_q.pop_front();
                    if (i_mat.r00 !== want.r00) report_mismatch("r00", i_mat.r00, want.r00);
                    if (i_mat.r01 !== want.r01) report_mismatch("r01", i_mat.r01, want.r01);
                    if (i_mat.r02 !== want.r02) report_mismatch("r02", i_mat.r02, want.r02);
                    if (i_mat.r10 !== want.r10) report_mismatch("r10", i_mat.r10, want.r10);
                    if (i_mat.r11 !== want.r11) report_mismatch("r11", i_mat.r11, want.r11);
                    if (i_mat.r12 !== want.r12) report_mismatch("r12", i_mat.r12, want.r12);
                    if (i_mat.r20 !== want.r20) report_mismatch("r20", i_mat.r20, want.r20);
                    if (i_mat.r21 !== want.r21) report_mismatch("r21", i_mat.r21, want.r21);
                    if (i_mat.r22 !== want.r22) report_mismatch("r22", i_mat.r22, want.r22);
                    if (i_mat.degenerate !== want.degenerate) begin
                        report_mismatch("degenerate", i_mat.degenerate, want.degenerate);
                    end
                end
            end
        end
    end

endmodule

/* test/align_z_axis_rotation_matrix_unit_tb.sv */
// testbench top for the z-axis alignment rotation unit: stimulus and verdict
// depends on azr_pkg, azr_rot_checker and the unit itself
module align_z_axis_rotation_matrix_unit_tb import azr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_vel i_vel = '0;
    logic o_busy;
    logic o_valid;
    t_rot o_mat;
    int   fail_cnt;
    int   pending;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    align_z_axis_rotation_matrix_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_vel(i_vel), .o_valid(o_valid), .o_mat(o_mat)
    );

    azr_rot_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_vel(i_vel), .i_valid(o_valid), .i_mat(o_mat),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    // one vector beat, with a random gap ahead of it unless running back to back
    task automatic send_vel(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_vel <= '{vel_x: x, vel_y: y, vel_z: z};
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_comp(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 16) - 8);
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(0, 1024) - 512);
        endcase
    endfunction

    initial begin
        bit burst;
        int cnt;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: axes, zero vector, extremes, near -z
        send_vel(16'h0000, 16'h0000, 16'h0100, 0);
        send_vel(16'h0000, 16'h0000, 16'h0000, 0);
        send_vel(16'h0000, 16'h0000, 16'hff00, 0);
        send_vel(16'h0000, 16'h0000, 16'h8000, 0);
        send_vel(16'h0000, 16'h0000, 16'h7fff, 0);
        send_vel(16'h0100, 16'h0000, 16'h0000, 0);
        send_vel(16'h0000, 16'h0100, 16'h0000, 0);
        send_vel(16'h8000, 16'h8000, 16'h8000, 0);
        send_vel(16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_vel(16'h8000, 16'h7fff, 16'h0000, 0);
        send_vel(16'h0001, 16'h0000, 16'h8000, 0);
        send_vel(16'h0000, 16'hffff, 16'h8000, 0);
        send_vel(16'h0001, 16'h0001, 16'h0001, 0);
        send_vel(16'hffff, 16'hffff, 16'hffff, 0);
        send_vel(16'h0001, 16'h0001, 16'h7fff, 0);
        send_vel(16'h5555, 16'haaaa, 16'h5555, 0);

        // random: mixed magnitudes, some bursts with no gaps
        burst = 0;
        cnt = 0;
        for (int k = 0; k < 1440; k++) begin
            if (cnt == 0) begin
                burst = $urandom_range(0, 3) == 0;
                cnt = $urandom_range(5, 40);
            end
            cnt--;
            if ($urandom_range(0, 19) == 0) begin
                send_vel(16'h0000, 16'h0000, rand_comp($urandom_range(0, 3)), burst);
            end else begin
                send_vel(rand_comp($urandom_range(0, 3)), rand_comp($urandom_range(0, 3)),
                         rand_comp($urandom_range(0, 3)), burst);
            end
        end
        i_start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // guard against a hung pipeline
    initial begin
        #200000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
